>>> rtl/core/sspq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
`timescale 1ns / 1ps

package sspq_pkg;

  // Default number of queue slots
  localparam int unsigned DEF_CAPACITY = 16;

  // Operation codes
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Input beat
  typedef struct packed {
    op_e         opcode;
    logic [15:0] entry_id;
    logic [7:0]  entry_priority;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    status_e     status;
    logic [15:0] out_id;
    logic [4:0]  occupancy;
  } out_beat_t;

  // Contents of one slot
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
  } slot_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic  enq;
    logic  deq;
    slot_t new_slot;
  } cell_ctrl_t;

endpackage

>>> rtl/core/sspq_cell.sv
// One slot of the sorted shift chain: holds an entry, shifts or takes the new one.
`timescale 1ns / 1ps

module sspq_cell (
  input  logic               clk_i,
  input  sspq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  sspq_pkg::slot_t    left_i,
  input  logic               left_ins_i,
  input  sspq_pkg::slot_t    right_i,
  output sspq_pkg::slot_t    data_o,
  output logic               ins_o
);

  sspq_pkg::slot_t data_q;
  sspq_pkg::slot_t data_d;

  // At or past the insertion point: empty, or holding a strictly larger number
  assign ins_o = !occupied_i || (data_q.pri > ctrl_i.new_slot.pri);

  // Insert moves the chain right from the insertion point; remove moves it left
  always_comb begin
    data_d = data_q;
    if (ctrl_i.enq) begin
      if (ins_o) begin
        data_d = left_ins_i ? left_i : ctrl_i.new_slot;
      end
    end else if (ctrl_i.deq) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/core/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built as a chain of slot cells.
// A result appears in the output register in the cycle after its input beat is taken.
// Throughput: one beat per cycle while the output is not stalled; every slot compares
// against the new priority in parallel and the whole chain shifts in the same cycle.
// Reset clears the entry count and the output valid at once; slot contents are
// undefined until written and are only read below the entry count.
`timescale 1ns / 1ps

module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY = sspq_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sspq_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sspq_pkg::out_beat_t out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count_q;
  logic [CW-1:0]       count_d;
  logic                out_valid_q;
  logic                out_valid_d;
  sspq_pkg::out_beat_t out_data_q;
  sspq_pkg::out_beat_t out_data_d;
  logic                in_fire;
  logic                full;
  logic                empty;
  logic [CW+4:0]       occ_ext;
  sspq_pkg::cell_ctrl_t ctrl;
  sspq_pkg::slot_t     cell_data [CAPACITY];
  logic                cell_ins  [CAPACITY];

  // Input is taken whenever the result register is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  // Command to the cells
  always_comb begin
    ctrl.enq          = in_fire && (in_data_i.opcode == sspq_pkg::OP_ENQ) && !full;
    ctrl.deq          = in_fire && (in_data_i.opcode == sspq_pkg::OP_DEQ) && !empty;
    ctrl.new_slot.id  = in_data_i.entry_id;
    ctrl.new_slot.pri = in_data_i.entry_priority;
  end

  // Slot chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            occ;
    sspq_pkg::slot_t left;
    logic            left_ins;
    sspq_pkg::slot_t right;

    assign occ = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left     = ctrl.new_slot;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left     = cell_data[i-1];
      assign left_ins = cell_ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    sspq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occ),
      .left_i     (left),
      .left_ins_i (left_ins),
      .right_i    (right),
      .data_o     (cell_data[i]),
      .ins_o      (cell_ins[i])
    );
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CW'(1);
    end
  end

  assign occ_ext = {5'b0, count_d};

  // Result beat
  always_comb begin
    out_data_d.status    = sspq_pkg::ST_OK;
    out_data_d.out_id    = '0;
    out_data_d.occupancy = occ_ext[4:0];
    if (in_data_i.opcode == sspq_pkg::OP_ENQ) begin
      if (full) begin
        out_data_d.status = sspq_pkg::ST_FULL;
      end
    end else if (empty) begin
      out_data_d.status = sspq_pkg::ST_EMPTY;
    end else begin
      out_data_d.out_id = cell_data[0].id;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/sspq_chk.sv
// Port-level checks for the stable sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module sspq_chk #(
  parameter int unsigned CAPACITY = sspq_pkg::DEF_CAPACITY
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sspq_pkg::in_beat_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sspq_pkg::out_beat_t out_data_o
);

  localparam logic [4:0] OCC_FULL = 5'(CAPACITY);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Every accepted input beat yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Empty dequeue reports nothing held and no id
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == sspq_pkg::ST_EMPTY) |->
      (out_data_o.occupancy == 5'd0) && (out_data_o.out_id == 16'd0))
    else $error("empty status with entries or id");

  // Full enqueue reports a full queue and no id
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == sspq_pkg::ST_FULL) |->
      (out_data_o.occupancy == OCC_FULL) && (out_data_o.out_id == 16'd0))
    else $error("full status with wrong occupancy or id");

endmodule

bind stable_sorted_priority_queue sspq_chk #(.CAPACITY(CAPACITY)) u_sspq_chk (.*);

>>> tb/sv/stable_sorted_priority_queue_tb.sv
// Self-checking testbench for the stable sorted priority queue.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_tb;
  import sspq_pkg::*;

  localparam int CAPACITY    = DEF_CAPACITY;
  localparam int RANDOM_BEATS = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  stable_sorted_priority_queue #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock and reset
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Shadow copy of the queue contents, kept in service order
  slot_t     shadow_slots[CAPACITY];
  int        shadow_count = 0;

  in_beat_t  pending_beats[$];
  out_beat_t expected_results[$];
  int        mismatches  = 0;
  int        cycle_count = 0;

  // Apply one beat to the shadow queue and return the result it should produce
  function automatic out_beat_t shadow_queue_step(in_beat_t beat);
    out_beat_t res;
    int        pos;
    int        i;
    res.status    = ST_OK;
    res.out_id    = '0;
    if (beat.opcode == OP_ENQ) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // new entry lands behind every entry of lower or equal priority
        pos = 0;
        while (pos < shadow_count && shadow_slots[pos].pri <= beat.entry_priority) pos++;
        for (i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i - 1];
        shadow_slots[pos].id  = beat.entry_id;
        shadow_slots[pos].pri = beat.entry_priority;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_id = shadow_slots[0].id;
        for (i = 1; i < shadow_count; i++) shadow_slots[i - 1] = shadow_slots[i];
        shadow_count--;
      end
    end
    res.occupancy = 5'(shadow_count);
    return res;
  endfunction

  function automatic in_beat_t make_beat(op_e op, logic [15:0] id, logic [7:0] pri);
    in_beat_t beat;
    beat.opcode         = op;
    beat.entry_id       = id;
    beat.entry_priority = pri;
    return beat;
  endfunction

  // Random beat; priorities often clustered so that ties are common
  function automatic in_beat_t random_beat(int enq_pct);
    logic [7:0] pri;
    op_e        op;
    case ($urandom_range(0, 3))
      0:       pri = 8'($urandom_range(0, 3));
      1:       pri = 8'($urandom_range(252, 255));
      default: pri = 8'($urandom_range(0, 255));
    endcase
    op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
    return make_beat(op, 16'($urandom_range(0, 65535)), pri);
  endfunction

  // Stimulus: directed corners, then random fill / drain / mixed phases
  initial begin
    int queued;
    int phase_len;
    int enq_pct;

    // dequeue from an empty queue
    pending_beats.push_back(make_beat(OP_DEQ, 16'hFFFF, 8'hFF));
    // field extremes and ties, including a tie with the head
    pending_beats.push_back(make_beat(OP_ENQ, 16'h0000, 8'h00));
    pending_beats.push_back(make_beat(OP_ENQ, 16'hFFFF, 8'hFF));
    pending_beats.push_back(make_beat(OP_ENQ, 16'h1111, 8'h80));
    pending_beats.push_back(make_beat(OP_ENQ, 16'h2222, 8'h80));
    pending_beats.push_back(make_beat(OP_ENQ, 16'h3333, 8'h80));
    pending_beats.push_back(make_beat(OP_ENQ, 16'h4444, 8'h00));
    pending_beats.push_back(make_beat(OP_ENQ, 16'hAAAA, 8'hFF));
    pending_beats.push_back(make_beat(OP_ENQ, 16'h5555, 8'h7F));
    // drain past empty
    repeat (9) pending_beats.push_back(make_beat(OP_DEQ, 16'h0000, 8'h00));

    // random phases: fill-heavy phases run into the full case,
    // drain-heavy ones into the empty case
    queued = 0;
    while (queued < RANDOM_BEATS) begin
      phase_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0:       enq_pct = 90;
        1:       enq_pct = 10;
        default: enq_pct = 50;
      endcase
      repeat (phase_len) pending_beats.push_back(random_beat(enq_pct));
      queued += phase_len;
    end

    // wait for every beat to be taken and every result to be checked
    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver: bursts of beats separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(shadow_queue_step(in_data_i));
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled beat
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_beats.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_beats.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat and run the output stall pattern
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: status %0d out_id %0h occupancy %0d",
                 out_data_o.status, out_data_o.out_id, out_data_o.occupancy);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
            mismatches++;
          end
          if (out_data_o.out_id !== want.out_id) begin
            $error("out_id: expected %0h, actual %0h", want.out_id, out_data_o.out_id);
            mismatches++;
          end
          if (out_data_o.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy,
                   out_data_o.occupancy);
            mismatches++;
          end
        end
      end

      // stall modes: none, light random, heavy
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 2) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/core/sspq_pkg.sv
rtl/core/sspq_cell.sv
rtl/core/stable_sorted_priority_queue.sv
rtl/core/sspq_chk.sv
tb/sv/stable_sorted_priority_queue_tb.sv
